// File: rtl/encfl_pkg.sv
// Package of shared types, constants and frame decode functions for the encoder frame check block.
`default_nettype none

package encfl_pkg;

	localparam int ANGLE_W     = 12;
	localparam int CNT_W       = 4;
	localparam int FRAME_W     = 18;
	localparam int WORD_W      = 24;
	localparam int CH_W        = 2;
	localparam int NUM_OFFSETS = 3;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int CHANNELS_DEF = 3;

	localparam logic [ANGLE_W-1:0] THRESH_RST  = ANGLE_W'(55);
	localparam logic [CNT_W-1:0]   HOLDOFF_RST = CNT_W'(3);

	typedef enum logic [2:0] {
		REG_ZERO_CH0 = 3'd0,
		REG_ZERO_CH1 = 3'd1,
		REG_ZERO_CH2 = 3'd2,
		REG_THRESH   = 3'd3,
		REG_HOLDOFF  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_OFFSETS-1:0][ANGLE_W-1:0] zero_offset;
		logic [ANGLE_W-1:0]                  jump_threshold;
		logic [CNT_W-1:0]                    outlier_holdoff;
	} cfg_t;

	// The frame is bits 22 to 5 of the raw word; bit 23 is a dummy lead bit.
	function automatic logic [FRAME_W-1:0] frame_of(input logic [WORD_W-1:0] word);
		return word[22:5];
	endfunction

	// Even parity over all bits, OCF set, COF clear, no magnet alarms; LIN is ignored.
	function automatic logic frame_ok(input logic [FRAME_W-1:0] frame);
		return !(^frame) && frame[5] && !frame[4] && !frame[2] && !frame[1];
	endfunction

	function automatic logic [ANGLE_W-1:0] raw_angle(input logic [FRAME_W-1:0] frame);
		return frame[17:6];
	endfunction

endpackage

`default_nettype wire

// File: rtl/encoder_frame_check_limit_filter_top.sv
// Top level of the encoder frame check and glitch limit filter.
//
// Usage: each input transfer carries an encoder channel number and the three
// raw SSI bytes read from that encoder. Every input transfer produces exactly
// one output transfer with the filtered, zero-corrected angle and a flag that
// says whether the frame passed its parity and status checks. A rejected
// frame, or a channel beyond the configured count, gives position zero and
// valid_res low and leaves that channel's filter state alone.
// An input transfer is first captured in the input register; the check and
// limiter logic then feed the output register, which offers the result.
// Throughput is one transfer per cycle while the receiver does not stall, since
// the channel state is updated at the same edge that loads the output register,
// so the next item already sees it.
// When the receiver stalls, the output register holds its transfer and the
// input register fills; item_ready drops only when both are occupied.
// Reset clears both pipeline stages, all channel state, the offsets, and sets
// the threshold to 55 and the holdoff to 3. The APB-style port always answers
// at once; configuration should only be written while the block is idle.
`default_nettype none

module encoder_frame_check_limit_filter_top
	import encfl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire logic [CH_W-1:0]    channel,
	input  wire logic [WORD_W-1:0]  frame_bytes,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic      [ANGLE_W-1:0] position,
	output logic                    valid_res
);

	cfg_t cfg;

	// Input stage.
	logic              valid_s1;
	logic [CH_W-1:0]   channel_s1;
	logic [WORD_W-1:0] frame_s1;

	// Output stage.
	logic               valid_s2;
	logic [ANGLE_W-1:0] position_s2;
	logic               valid_res_s2;

	logic               adv;
	logic [ANGLE_W-1:0] position_c;
	logic               valid_res_c;

	encfl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The output register can take a new result when it is empty or being emptied.
	assign adv        = !valid_s2 || res_ready;
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			channel_s1 <= channel;
			frame_s1   <= frame_bytes;
		end
	end

	encfl_limiter #(
		.CHANNELS (CHANNELS)
	) u_limiter (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.upd         (valid_s1 && adv),
		.channel     (channel_s1),
		.frame_bytes (frame_s1),
		.position    (position_c),
		.valid_res   (valid_res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			position_s2  <= position_c;
			valid_res_s2 <= valid_res_c;
		end
	end

	assign res_valid = valid_s2;
	assign position  = position_s2;
	assign valid_res = valid_res_s2;

endmodule

`default_nettype wire

// File: rtl/encfl_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module encfl_regs
	import encfl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_offset     <= '0;
			cfg_q.jump_threshold  <= THRESH_RST;
			cfg_q.outlier_holdoff <= HOLDOFF_RST;
		end else if (wr_en) begin
			case (idx)
				REG_ZERO_CH0: cfg_q.zero_offset[0]   <= pwdata[ANGLE_W-1:0];
				REG_ZERO_CH1: cfg_q.zero_offset[1]   <= pwdata[ANGLE_W-1:0];
				REG_ZERO_CH2: cfg_q.zero_offset[2]   <= pwdata[ANGLE_W-1:0];
				REG_THRESH:   cfg_q.jump_threshold  <= pwdata[ANGLE_W-1:0];
				REG_HOLDOFF:  cfg_q.outlier_holdoff <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ZERO_CH0: prdata = DATA_W'(cfg_q.zero_offset[0]);
			REG_ZERO_CH1: prdata = DATA_W'(cfg_q.zero_offset[1]);
			REG_ZERO_CH2: prdata = DATA_W'(cfg_q.zero_offset[2]);
			REG_THRESH:   prdata = DATA_W'(cfg_q.jump_threshold);
			REG_HOLDOFF:  prdata = DATA_W'(cfg_q.outlier_holdoff);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/encfl_limiter.sv
// Frame check, zero correction and per-channel glitch limiter with its state.
`default_nettype none

module encfl_limiter
	import encfl_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cfg_t                    cfg,
	input  wire logic               upd,
	input  wire logic [CH_W-1:0]    channel,
	input  wire logic [WORD_W-1:0]  frame_bytes,
	output logic      [ANGLE_W-1:0] position,
	output logic                    valid_res
);

	logic [ANGLE_W-1:0] held_q  [CHANNELS];
	logic [CNT_W-1:0]   count_q [CHANNELS];

	logic [FRAME_W-1:0] frame;
	logic               ch_ok;
	logic               ok;
	logic [ANGLE_W-1:0] offset;
	logic [ANGLE_W-1:0] angle;
	logic [ANGLE_W-1:0] held;
	logic [CNT_W-1:0]   count;
	logic [ANGLE_W-1:0] step;
	logic               take;
	logic [ANGLE_W-1:0] held_nxt;
	logic [CNT_W-1:0]   count_nxt;

	assign frame  = frame_of(frame_bytes);
	assign ch_ok  = int'(channel) < CHANNELS;
	assign ok     = ch_ok && frame_ok(frame);
	// Channels beyond the offset registers run without a zero correction.
	assign offset = (int'(channel) < NUM_OFFSETS) ? cfg.zero_offset[channel] : '0;
	assign angle  = raw_angle(frame) - offset;

	always_comb begin
		held  = '0;
		count = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (i == int'(channel)) begin
				held  = held_q[i];
				count = count_q[i];
			end
		end
	end

	assign step = (angle >= held) ? (angle - held) : (held - angle);

	always_comb begin
		take = 1'b1;
		if (step >= cfg.jump_threshold) begin
			take = (count >= cfg.outlier_holdoff);
		end
		held_nxt  = take ? angle : held;
		count_nxt = take ? '0 : count + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				held_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (upd && ok) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (i == int'(channel)) begin
					held_q[i]  <= held_nxt;
					count_q[i] <= count_nxt;
				end
			end
		end
	end

	assign position  = ok ? held_nxt : '0;
	assign valid_res = ok;

endmodule

`default_nettype wire

// File: rtl/encfl_checker.sv
// Port-level checker for the encoder frame check block and its bind statement.
`default_nettype none

module encfl_checker
	import encfl_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pwrite,
	input wire logic [ADDR_W-1:0]  paddr,
	input wire logic [DATA_W-1:0]  pwdata,
	input wire logic [DATA_W-1:0]  prdata,
	input wire logic               pready,
	input wire logic               item_valid,
	input wire logic               item_ready,
	input wire logic [CH_W-1:0]    channel,
	input wire logic [WORD_W-1:0]  frame_bytes,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic [ANGLE_W-1:0] position,
	input wire logic               valid_res
);

	// A waiting input transfer keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(channel) && $stable(frame_bytes))
		else $error("input payload changed while waiting");

	// A stalled output transfer keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(position) && $stable(valid_res))
		else $error("output payload changed while stalled");

	// A rejected frame always reports position zero.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> position == '0)
		else $error("rejected frame with non-zero position");

	// Input back-pressure only comes from a stalled output.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> res_valid && !res_ready)
		else $error("input stalled without an output stall");

	// A threshold write reads back on the following cycle.
	a_thresh_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr == ADDR_W'(4 * REG_THRESH))
		##1 (paddr == ADDR_W'(4 * REG_THRESH))
		|-> prdata == DATA_W'($past(pwdata[ANGLE_W-1:0])))
		else $error("threshold register read-back mismatch");

endmodule

bind encoder_frame_check_limit_filter_top encfl_checker u_encfl_checker (.*);

`default_nettype wire
